@@ hw/rtl/dlmt_pkg.sv @@
// Shared types, constants and helpers for the DFA longest-match tokenizer.
`timescale 1ns / 1ps
package dlmt_pkg;

   // DFA geometry
   localparam int NUM_STATES  = 256;
   localparam int STATE_BITS  = $clog2(NUM_STATES);
   localparam int SYMBOL_BITS = 8;
   localparam int COUNT_BITS  = 16;
   localparam int TRANS_DEPTH = NUM_STATES << SYMBOL_BITS;
   localparam int TRANS_ADDR_BITS = STATE_BITS + SYMBOL_BITS;

   // Transition entry: flag bit over the next state, flag set means no transition
   localparam int TRANS_WIDTH  = STATE_BITS + 1;
   // Accept entry: accepting flag over the 16-bit token value
   localparam int VALUE_BITS   = 16;
   localparam int ACCEPT_WIDTH = VALUE_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Token reported when nothing matched (-1)
   localparam logic signed [VALUE_BITS:0] TOKEN_NONE = '1;

   // ASCII bounds for case folding
   localparam logic [SYMBOL_BITS-1:0] CHAR_UPPER_A = SYMBOL_BITS'(8'h41);
   localparam logic [SYMBOL_BITS-1:0] CHAR_UPPER_Z = SYMBOL_BITS'(8'h5A);
   localparam logic [SYMBOL_BITS-1:0] CHAR_CASE_OFFSET = SYMBOL_BITS'(8'h20);
   localparam logic [SYMBOL_BITS-1:0] CHAR_NUL = '0;

   typedef enum logic [1:0] {
      FUNC_LOAD_TRANS  = 2'd0,
      FUNC_LOAD_ACCEPT = 2'd1,
      FUNC_CHAR        = 2'd2,
      FUNC_END         = 2'd3
   } func_type;

   // Fold an upper case letter to lower case when enabled
   function automatic logic [SYMBOL_BITS-1:0] fold_char(input logic [SYMBOL_BITS-1:0] sym,
                                                        input logic ignore_case);
      logic is_upper;
      is_upper = (sym >= CHAR_UPPER_A) && (sym <= CHAR_UPPER_Z);
      if (ignore_case && is_upper) begin
         fold_char = sym + CHAR_CASE_OFFSET;
      end else begin
         fold_char = sym;
      end
   endfunction

endpackage

@@ hw/rtl/dlmt_if.sv @@
// Request and response channel interfaces for the DFA tokenizer.
`timescale 1ns / 1ps
interface dlmt_req_if import dlmt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   func_type                 func;
   logic [7:0]               state_sel;
   logic [7:0]               symbol;
   logic signed [8:0]        target_state;
   logic                     accepting;
   logic [15:0]              accept_value;

   modport source (output valid, func, state_sel, symbol, target_state, accepting,
                   accept_value, input ready);
   modport sink   (input valid, func, state_sel, symbol, target_state, accepting,
                   accept_value, output ready);
endinterface

interface dlmt_rsp_if ();
   logic                     valid;
   logic                     ready;
   logic signed [16:0]       token_value;
   logic [15:0]              matched_length;
   logic [15:0]              pushback_count;

   modport source (output valid, token_value, matched_length, pushback_count,
                   input ready);
   modport sink   (input valid, token_value, matched_length, pushback_count,
                   output ready);
endinterface

@@ hw/rtl/dlmt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dlmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/dfa_longest_match_tokenizer.sv @@
// Top level of the table-driven DFA longest-match tokenizer.
`timescale 1ns / 1ps
// Usage:
//   req_bus carries one beat per item: a transition load, an accept load, a
//   character or an end of stream. rsp_bus carries one beat per finished token:
//   token value (-1 if nothing matched), matched length and pushback count.
//   csr_wr_en/csr_wr_data write ignore_case; write it only while the block is idle.
// Flow:
//   Load beats are written into the tables on the accepting edge, one per cycle
//   while no step is pending. A character or end beat holds req_bus.ready low until
//   its step resolves; the transition RAM read issued on the accepting edge returns
//   in the next cycle. The accept-flag read of the new state overlaps the next beat's
//   acceptance. A token enters the response register when the step ending it resolves.
// Reset:
//   reset clears the DFA position, counters, match record and ignore_case; the
//   tables are not cleared and every entry must be loaded before matching.
// Backpressure:
//   The response register holds while rsp_bus.ready is low; characters that do
//   not end a token keep flowing, and a beat that ends one waits for the slot.
module dfa_longest_match_tokenizer import dlmt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   dlmt_req_if.sink    req_bus,
   dlmt_rsp_if.source  rsp_bus
);

   // config
   logic ignore_case_ff, ignore_case_in;

   // step stage
   logic s1_valid_ff, s1_valid_in;
   logic s1_end_ff, s1_end_in;

   // accept check stage
   logic                  s2_valid_ff, s2_valid_in;
   logic [STATE_BITS-1:0] s2_state_ff, s2_state_in;

   // DFA position and match record
   logic [STATE_BITS-1:0] cur_ff, cur_in;
   logic [COUNT_BITS-1:0] consumed_ff, consumed_in;
   logic                  best_valid_ff, best_valid_in;
   logic [STATE_BITS-1:0] best_state_ff, best_state_in;
   logic [VALUE_BITS-1:0] best_value_ff, best_value_in;
   logic [COUNT_BITS-1:0] best_len_ff, best_len_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_BITS:0] rsp_token_ff, rsp_token_in;
   logic [15:0]             rsp_len_ff, rsp_len_in;
   logic [15:0]             rsp_push_ff, rsp_push_in;

   // handshakes and decode
   logic req_fire, load_trans, load_accept, step_item;
   logic out_free, s1_report, s1_fire, s1_advance, acc_hit;
   logic [COUNT_BITS-1:0] count_inc, report_count;

   // memory ports
   logic [TRANS_ADDR_BITS-1:0] trans_wr_addr, trans_rd_addr;
   logic [TRANS_WIDTH-1:0]     trans_wr_data, trans_rd_data;
   logic [ACCEPT_WIDTH-1:0]    acc_wr_data, acc_rd_data;

   assign req_bus.ready = !s1_valid_ff;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign load_trans    = req_fire && (req_bus.func == FUNC_LOAD_TRANS);
   assign load_accept   = req_fire && (req_bus.func == FUNC_LOAD_ACCEPT);
   assign step_item     = req_fire &&
                          ((req_bus.func == FUNC_CHAR) || (req_bus.func == FUNC_END));

   // table addresses: loads write straight from the beat, characters read
   assign trans_wr_addr = {req_bus.state_sel, req_bus.symbol};
   assign trans_wr_data = req_bus.target_state[8] ? {1'b1, STATE_BITS'(0)}
                                                  : {1'b0, req_bus.target_state[7:0]};
   assign trans_rd_addr = {cur_ff, fold_char(req_bus.symbol, ignore_case_ff)};
   assign acc_wr_data   = {req_bus.accepting, req_bus.accept_value};

   dlmt_ram #(
      .WIDTH (TRANS_WIDTH),
      .DEPTH (TRANS_DEPTH)
   ) u_trans_ram (
      .clock   (clock),
      .wr_en   (load_trans),
      .wr_addr (trans_wr_addr),
      .wr_data (trans_wr_data),
      .rd_en   (step_item),
      .rd_addr (trans_rd_addr),
      .rd_data (trans_rd_data)
   );

   dlmt_ram #(
      .WIDTH (ACCEPT_WIDTH),
      .DEPTH (NUM_STATES)
   ) u_accept_ram (
      .clock   (clock),
      .wr_en   (load_accept),
      .wr_addr (req_bus.state_sel),
      .wr_data (acc_wr_data),
      .rd_en   (s1_advance),
      .rd_addr (trans_rd_data[STATE_BITS-1:0]),
      .rd_data (acc_rd_data)
   );

   // step decision: end beats, NUL characters and failed lookups report
   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign count_inc    = (consumed_ff == COUNT_MAX) ? consumed_ff : consumed_ff + 1'b1;
   assign s1_report    = s1_end_ff || trans_rd_data[STATE_BITS];
   assign s1_fire      = s1_valid_ff && (!s1_report || out_free);
   assign s1_advance   = s1_fire && !s1_report;
   assign report_count = s1_end_ff ? consumed_ff : count_inc;
   assign acc_hit      = s2_valid_ff && acc_rd_data[VALUE_BITS];

   always_comb begin
      ignore_case_in = csr_wr_en ? csr_wr_data : ignore_case_ff;

      s1_valid_in = step_item ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s1_end_in   = step_item ? ((req_bus.func == FUNC_END) || (req_bus.symbol == CHAR_NUL))
                              : s1_end_ff;

      s2_valid_in = s1_advance;
      s2_state_in = trans_rd_data[STATE_BITS-1:0];

      cur_in        = cur_ff;
      consumed_in   = consumed_ff;
      best_valid_in = best_valid_ff;
      best_state_in = best_state_ff;
      best_value_in = best_value_ff;
      best_len_in   = best_len_ff;

      // match record: new accepting state, or an accept load patches the value
      if (acc_hit) begin
         best_valid_in = 1'b1;
         best_state_in = s2_state_ff;
         best_len_in   = consumed_ff;
         best_value_in = (load_accept && (req_bus.state_sel == s2_state_ff))
                         ? req_bus.accept_value : acc_rd_data[VALUE_BITS-1:0];
      end else if (load_accept && best_valid_ff && (req_bus.state_sel == best_state_ff)) begin
         best_value_in = req_bus.accept_value;
      end

      // step or restart
      if (s1_advance) begin
         cur_in      = trans_rd_data[STATE_BITS-1:0];
         consumed_in = count_inc;
      end else if (s1_fire) begin
         cur_in        = '0;
         consumed_in   = '0;
         best_valid_in = 1'b0;
         best_state_in = '0;
         best_len_in   = '0;
      end

      // response slot
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_token_in = rsp_token_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_push_in  = rsp_push_ff;
      if (s1_fire && s1_report) begin
         rsp_valid_in = 1'b1;
         rsp_token_in = best_valid_ff ? $signed({1'b0, best_value_ff}) : TOKEN_NONE;
         rsp_len_in   = 16'(best_len_ff);
         rsp_push_in  = 16'(report_count - best_len_ff);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_case_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         cur_ff         <= '0;
         consumed_ff    <= '0;
         best_valid_ff  <= 1'b0;
         best_state_ff  <= '0;
         best_len_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ignore_case_ff <= ignore_case_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         cur_ff         <= cur_in;
         consumed_ff    <= consumed_in;
         best_valid_ff  <= best_valid_in;
         best_state_ff  <= best_state_in;
         best_len_ff    <= best_len_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_end_ff     <= s1_end_in;
      s2_state_ff   <= s2_state_in;
      best_value_ff <= best_value_in;
      rsp_token_ff  <= rsp_token_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_push_ff   <= rsp_push_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.token_value    = rsp_token_ff;
   assign rsp_bus.matched_length = rsp_len_ff;
   assign rsp_bus.pushback_count = rsp_push_ff;

endmodule
